@@ src/fpa_pkg.sv @@
// Shared types and constants for the Q24.8 fixed-point arithmetic unit.
package fpa_pkg;

    localparam int W = 32;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_GT       = 4'd4,
        CMD_LT       = 4'd5,
        CMD_GE       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_INC      = 4'd10,
        CMD_DEC      = 4'd11,
        CMD_MIN      = 4'd12,
        CMD_MAX      = 4'd13,
        CMD_FROM_INT = 4'd14,
        CMD_TO_INT   = 4'd15
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_QUICK = 2'd0,
        KIND_MUL   = 2'd1,
        KIND_DIV   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [3:0]          command;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [W-1:0] result_value;
        logic                compare_true;
        logic                divide_by_zero;
    } rsp_t;

    // Contents of one cell of the chain
    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic             neg;
        logic [W-1:0]     mag_a;
        logic [W-1:0]     mag_b;
        logic [W-1:0]     rem;
        logic [W-1:0]     quo;
        logic [2*W-1:0]   prod;
        logic [W-1:0]     quick;
        logic             cmp;
        logic             dz;
    } stage_t;

endpackage

@@ src/fpa_front.sv @@
// Operand decode: magnitudes, signs and the results of the quick commands.
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic           valid,
    input  fpa_pkg::req_t  req,
    output fpa_pkg::stage_t stage
);
    localparam int W = fpa_pkg::W;

    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic [W-1:0]        mag_a;
    logic [W-1:0]        mag_b;
    logic [W-1:0]        t;
    logic                a_lt_b;
    logic                b_lt_a;

    always_comb
    begin
        a      = req.operand_a;
        b      = req.operand_b;
        mag_a  = a[W-1] ? (W'(0) - a) : a;
        mag_b  = b[W-1] ? (W'(0) - b) : b;
        a_lt_b = a < b;
        b_lt_a = b < a;
        t      = mag_a >> FRAC_BITS;

        stage.valid = valid;
        stage.neg   = a[W-1] ^ b[W-1];
        stage.mag_a = mag_a;
        stage.mag_b = mag_b;
        stage.rem   = '0;
        stage.quo   = '0;
        stage.prod  = '0;
        stage.quick = '0;
        stage.cmp   = 1'b0;
        stage.dz    = 1'b0;
        stage.kind  = fpa_pkg::KIND_QUICK;

        unique case (fpa_pkg::cmd_t'(req.command))
            fpa_pkg::CMD_ADD:      stage.quick = a + b;
            fpa_pkg::CMD_SUB:      stage.quick = a - b;
            fpa_pkg::CMD_MUL:      stage.kind  = fpa_pkg::KIND_MUL;
            fpa_pkg::CMD_DIV:
            begin
                stage.kind = fpa_pkg::KIND_DIV;
                stage.dz   = (b == '0);
            end
            fpa_pkg::CMD_GT:       stage.cmp   = b_lt_a;
            fpa_pkg::CMD_LT:       stage.cmp   = a_lt_b;
            fpa_pkg::CMD_GE:       stage.cmp   = !a_lt_b;
            fpa_pkg::CMD_LE:       stage.cmp   = !b_lt_a;
            fpa_pkg::CMD_EQ:       stage.cmp   = (a == b);
            fpa_pkg::CMD_NE:       stage.cmp   = (a != b);
            fpa_pkg::CMD_INC:      stage.quick = a + W'(1);
            fpa_pkg::CMD_DEC:      stage.quick = a - W'(1);
            fpa_pkg::CMD_MIN:      stage.quick = a_lt_b ? a : b;
            fpa_pkg::CMD_MAX:      stage.quick = b_lt_a ? a : b;
            fpa_pkg::CMD_FROM_INT: stage.quick = a << FRAC_BITS;
            fpa_pkg::CMD_TO_INT:   stage.quick = a[W-1] ? (W'(0) - t) : t;
            default:               stage.quick = '0;
        endcase
    end
endmodule

@@ src/fpa_cell.sv @@
// One cell: a restoring divide step and a shift-add multiply step.
module fpa_cell #(
    parameter int FRAC_BITS = 8,
    parameter int IDX       = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  fpa_pkg::stage_t d,
    output fpa_pkg::stage_t q
);
    localparam int W    = fpa_pkg::W;
    localparam int P    = W + FRAC_BITS - 1 - IDX;   // dividend bit handled here
    localparam int AIDX = (P >= FRAC_BITS) ? (P - FRAC_BITS) : 0;
    localparam int QIDX = (P < W) ? P : 0;
    localparam int MIDX = (IDX < W) ? IDX : 0;

    fpa_pkg::stage_t q_reg;
    fpa_pkg::stage_t q_next;
    logic            valid_reg;
    logic            dbit;
    logic [W:0]      trial;

    always_comb
    begin
        q_next = d;
        dbit   = (P >= FRAC_BITS) ? d.mag_a[AIDX] : 1'b0;
        trial  = {d.rem, dbit};
        if (trial >= {1'b0, d.mag_b})
        begin
            q_next.rem = W'(trial - {1'b0, d.mag_b});
            if (P < W)
                q_next.quo[QIDX] = 1'b1;
        end
        else
        begin
            q_next.rem = trial[W-1:0];
        end
        if (IDX < W && d.mag_b[MIDX])
            q_next.prod = d.prod + ({{W{1'b0}}, d.mag_a} << MIDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= q_next.valid;
    end

    // payload carries no reset
    always_ff @(posedge clk)
    begin
        if (adv)
            q_reg <= q_next;
    end

    always_comb
    begin
        q       = q_reg;
        q.valid = valid_reg;
    end
endmodule

@@ src/fixed_point_alu_q24_8_unit.sv @@
// Top level of the Q24.8 fixed-point arithmetic unit: cell chain and result register.
//
//  channel | direction | handshake            | beat payload
//  req     | in        | req_valid/req_ready  | command, operand_a, operand_b
//  rsp     | out       | rsp_valid/rsp_ready  | result_value, compare_true, divide_by_zero
//
// One beat is accepted every cycle while req_ready is high; every command passes through
// the chain of one cell per dividend bit and then the result register.
// The chain advances as a whole; a stalled result holds the chain and drops req_ready.
// Reset clears the valid bits only.
module fixed_point_alu_q24_8_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fpa_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fpa_pkg::rsp_t  rsp
);
    localparam int W = fpa_pkg::W;
    localparam int N = W + FRAC_BITS;

    fpa_pkg::stage_t chain [0:N];
    fpa_pkg::stage_t last;
    logic            adv;
    logic            rsp_valid_reg;
    fpa_pkg::rsp_t   rsp_reg;
    fpa_pkg::rsp_t   rsp_next;
    logic [2*W-1:0]  rounded;
    logic [W-1:0]    mq;

    assign adv       = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .valid (req_valid),
        .req   (req),
        .stage (chain[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fpa_cell #(.FRAC_BITS(FRAC_BITS), .IDX(i)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d     (chain[i]),
            .q     (chain[i+1])
        );
    end

    assign last = chain[N];

    always_comb
    begin
        rounded  = last.prod + ((2*W)'(1) << (FRAC_BITS - 1));
        mq       = W'(rounded >> FRAC_BITS);
        rsp_next.compare_true   = last.cmp;
        rsp_next.divide_by_zero = last.dz;
        unique case (last.kind)
            fpa_pkg::KIND_MUL: rsp_next.result_value = last.neg ? (W'(0) - mq) : mq;
            fpa_pkg::KIND_DIV:
                rsp_next.result_value = last.dz ? '0 :
                                        (last.neg ? (W'(0) - last.quo) : last.quo);
            default:           rsp_next.result_value = last.quick;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0)
        else $error("divide by zero beat with nonzero result");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.compare_true && rsp.divide_by_zero))
        else $error("compare and divide-by-zero flags both set");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |=> $stable(last.valid) && rsp_valid)
        else $error("chain moved during stall");
endmodule

@@ tb/sv/tb_fixed_point_alu_q24_8_unit.sv @@
// Self-checking testbench for the Q24.8 fixed-point arithmetic unit.
module tb_fixed_point_alu_q24_8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam int LATENCY = 32 + FRAC + 1;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    fpa_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_ready;
    fpa_pkg::rsp_t  rsp;

    fpa_pkg::req_t  pending_ops[$];
    fpa_pkg::rsp_t  expected_results[$];
    int    errors = 0;
    int    results_seen = 0;
    int    ops_sent = 0;
    int    src_gap = 0;
    int    sink_gap = 0;
    bit    req_taken = 1'b0;

    fixed_point_alu_q24_8_unit #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    function automatic bit [31:0] mag32(bit [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic fpa_pkg::rsp_t compute_result(fpa_pkg::req_t r);
        fpa_pkg::rsp_t o;
        bit [31:0] a;
        bit [31:0] b;
        bit [31:0] t;
        bit [63:0] prod;
        bit [95:0] quo;
        bit        neg;
        a = r.operand_a;
        b = r.operand_b;
        o = '0;
        neg = a[31] ^ b[31];
        case (fpa_pkg::cmd_t'(r.command))
            fpa_pkg::CMD_ADD: o.result_value = a + b;
            fpa_pkg::CMD_SUB: o.result_value = a - b;
            fpa_pkg::CMD_MUL:
            begin
                prod = {32'd0, mag32(a)} * {32'd0, mag32(b)};
                prod = (prod + (64'd1 << (FRAC - 1))) >> FRAC;
                o.result_value = neg ? -prod[31:0] : prod[31:0];
            end
            fpa_pkg::CMD_DIV:
            begin
                if (b == 0)
                    o.divide_by_zero = 1'b1;
                else
                begin
                    quo = ({64'd0, mag32(a)} << FRAC) / {64'd0, mag32(b)};
                    o.result_value = neg ? -quo[31:0] : quo[31:0];
                end
            end
            fpa_pkg::CMD_GT: o.compare_true = $signed(a) > $signed(b);
            fpa_pkg::CMD_LT: o.compare_true = $signed(a) < $signed(b);
            fpa_pkg::CMD_GE: o.compare_true = $signed(a) >= $signed(b);
            fpa_pkg::CMD_LE: o.compare_true = $signed(a) <= $signed(b);
            fpa_pkg::CMD_EQ: o.compare_true = a == b;
            fpa_pkg::CMD_NE: o.compare_true = a != b;
            fpa_pkg::CMD_INC: o.result_value = a + 1;
            fpa_pkg::CMD_DEC: o.result_value = a - 1;
            fpa_pkg::CMD_MIN: o.result_value = ($signed(a) < $signed(b)) ? a : b;
            fpa_pkg::CMD_MAX: o.result_value = ($signed(b) < $signed(a)) ? a : b;
            fpa_pkg::CMD_FROM_INT: o.result_value = a << FRAC;
            default:
            begin
                t = mag32(a) >> FRAC;
                o.result_value = a[31] ? -t : t;
            end
        endcase
        return o;
    endfunction

    function automatic bit [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
            4, 5: return $signed($urandom_range(0, 65535)) - 32768;
            6: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(fpa_pkg::cmd_t c, bit [31:0] a, bit [31:0] b);
        fpa_pkg::req_t r;
        r.command = c;
        r.operand_a = a;
        r.operand_b = b;
        pending_ops.push_back(r);
    endtask

    function automatic int draw_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // input side: note each accepted request beat and predict its result
    always @(posedge clk)
    begin
        req_taken = rst_n && req_valid && req_ready;
        if (req_taken)
            expected_results.push_back(compute_result(req));
    end

    // driver: present a beat at the falling edge, hold it until accepted, and drive rsp_ready with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (req_taken)
            begin
                ops_sent++;
                src_gap = draw_gap();
            end
            if (!(req_valid && !req_taken))
            begin
                if (src_gap > 0 || pending_ops.size() == 0)
                begin
                    if (src_gap > 0)
                        src_gap--;
                    req_valid <= 1'b0;
                end
                else
                begin
                    req <= pending_ops.pop_front();
                    req_valid <= 1'b1;
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                sink_gap = draw_gap();
            end
        end
    end

    // monitor: check each accepted result beat against the oldest prediction
    always @(posedge clk)
    begin
        fpa_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", rsp);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.result_value !== want.result_value)
                begin
                    $error("result_value: expected %h, got %h",
                           want.result_value, rsp.result_value);
                    errors++;
                end
                if (rsp.compare_true !== want.compare_true)
                begin
                    $error("compare_true: expected %b, got %b",
                           want.compare_true, rsp.compare_true);
                    errors++;
                end
                if (rsp.divide_by_zero !== want.divide_by_zero)
                begin
                    $error("divide_by_zero: expected %b, got %b",
                           want.divide_by_zero, rsp.divide_by_zero);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int waited;
        rst_n = 1'b0;

        // every command on extremes, then the named corner cases, then random commands
        for (int c = 0; c < 16; c++)
            queue_op(fpa_pkg::cmd_t'(c), 32'h8000_0000, 32'h7fff_ffff);
        queue_op(fpa_pkg::CMD_DIV, 32'h0000_1234, 32'd0);
        queue_op(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
        queue_op(fpa_pkg::CMD_DIV, 32'h7fff_ffff, 32'd1);
        queue_op(fpa_pkg::CMD_MUL, 32'h0000_0180, 32'hffff_ff80);
        queue_op(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_op(fpa_pkg::CMD_MIN, 32'd77, 32'd77);
        queue_op(fpa_pkg::CMD_MAX, 32'hffff_fff0, 32'hffff_fff0);
        queue_op(fpa_pkg::CMD_TO_INT, 32'hffff_ff01, 32'd0);
        queue_op(fpa_pkg::CMD_FROM_INT, 32'h00ff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 900; i++)
            queue_op(fpa_pkg::cmd_t'($urandom_range(0, 15)), pick_operand(),
                     pick_operand());

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_ops.size() == 0);
        @(negedge clk);
        wait (!req_valid);
        waited = 0;
        while (expected_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d commands, %0d results checked, all sixteen operations",
                 ops_sent, results_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
